@@ design/kls_pkg.sv @@
// Shared definitions for the keymap layer stack engine.
// Command codes, entry types, action codes, sequencer states and the
// result transfer struct; no dependencies.
package kls_pkg;

  // Default geometry
  localparam int KLS_ROWS        = 8;
  localparam int KLS_COLS        = 16;
  localparam int KLS_LAYERS      = 16;
  localparam int KLS_STACK_DEPTH = 8;

  // Table entry width
  localparam int WORD_W = 25;

  // Input commands
  localparam logic [1:0] FN_KEY       = 2'd0;
  localparam logic [1:0] FN_LED       = 2'd1;
  localparam logic [1:0] FN_WR_KEYMAP = 2'd2;
  localparam logic [1:0] FN_WR_COMP   = 2'd3;

  // Entry types; the codes above ET_COMMAND act as none
  localparam logic [3:0] ET_NONE     = 4'd0;
  localparam logic [3:0] ET_KEY      = 4'd1;
  localparam logic [3:0] ET_MOD      = 4'd2;
  localparam logic [3:0] ET_MOUSE    = 4'd3;
  localparam logic [3:0] ET_CONSUMER = 4'd4;
  localparam logic [3:0] ET_SYSTEM   = 4'd5;
  localparam logic [3:0] ET_LAYER    = 4'd6;
  localparam logic [3:0] ET_LOCK     = 4'd7;
  localparam logic [3:0] ET_UNLOCK   = 4'd8;
  localparam logic [3:0] ET_BASE_PP  = 4'd9;
  localparam logic [3:0] ET_BASE_SET = 4'd10;
  localparam logic [3:0] ET_COMMAND  = 4'd11;

  // Output actions
  localparam logic [2:0] ACT_KEY      = 3'd0;
  localparam logic [2:0] ACT_MOD      = 3'd1;
  localparam logic [2:0] ACT_MOUSE    = 3'd2;
  localparam logic [2:0] ACT_CONSUMER = 3'd3;
  localparam logic [2:0] ACT_SYSTEM   = 3'd4;
  localparam logic [2:0] ACT_COMMAND  = 3'd5;
  localparam logic [2:0] ACT_LEDS     = 3'd6;
  localparam logic [2:0] ACT_LOCK     = 3'd7;

  // LED bits and lock states
  localparam logic [2:0] LOCK_ON        = 3'b001;
  localparam logic [2:0] LOCK_OFF       = 3'b000;
  localparam logic [2:0] LED_CAPS       = 3'b010;
  localparam logic [2:0] LED_NUM_SCROLL = 3'b101;

  // Fixed layers driven by host LED reports
  localparam logic [3:0] LAYER_NUM_LOCK  = 4'd2;
  localparam logic [3:0] LAYER_CAPS_LOCK = 4'd4;
  localparam logic [3:0] LAYER_DEFAULT   = 4'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY,
    ST_KEY_REL,
    ST_ENTRY,
    ST_COMP_A,
    ST_COMP_A_EX,
    ST_COMP_B_EX,
    ST_LED_NUM,
    ST_LED_BASE,
    ST_LED_EMIT,
    ST_FLUSH
  } seq_state_t;

  // One result from the sequencer, or the end-of-item marker
  typedef struct packed {
    logic       valid;
    logic       flush;
    logic [2:0] action;
    logic [7:0] code;
    logic [7:0] mods;
    logic       act_pressed;
    logic [2:0] led_value;
  } emit_t;

  // Press record control
  typedef struct packed {
    logic set;
    logic clear;
  } press_ctl_t;

endpackage

@@ design/kls_tables.sv @@
// Keymap store and layer companion table, both synchronous memories.
// Written straight from accepted table-write commands; uses kls_pkg.
module kls_tables
  import kls_pkg::*;
#(
  parameter int ROWS   = KLS_ROWS,
  parameter int COLS   = KLS_COLS,
  parameter int LAYERS = KLS_LAYERS,
  localparam int DEPTH = LAYERS * ROWS * COLS,
  localparam int AW    = $clog2(DEPTH),
  localparam int LW    = $clog2(LAYERS)
) (
  input  logic              clk,
  input  logic              take,
  input  logic [1:0]        func,
  input  logic [10:0]       table_index,
  input  logic [WORD_W-1:0] table_word,
  input  logic [AW-1:0]     km_raddr,
  output logic [WORD_W-1:0] km_rdata,
  input  logic [LW-1:0]     cp_raddr,
  output logic [WORD_W-1:0] cp_rdata
);

  logic [WORD_W-1:0] km_mem [DEPTH];
  logic [WORD_W-1:0] cp_mem [LAYERS];
  logic              km_we;
  logic              cp_we;

  // Out-of-range writes are dropped
  assign km_we = take && (func == FN_WR_KEYMAP) && (int'(table_index) < DEPTH);
  assign cp_we = take && (func == FN_WR_COMP) && (int'(table_index) < LAYERS);

  // Keymap store
  always_ff @(posedge clk) begin
    if (km_we) begin
      km_mem[AW'(table_index)] <= table_word;
    end
    km_rdata <= km_mem[km_raddr];
  end

  // Companion table
  always_ff @(posedge clk) begin
    if (cp_we) begin
      cp_mem[LW'(table_index)] <= table_word;
    end
    cp_rdata <= cp_mem[cp_raddr];
  end

endmodule

@@ design/kls_press.sv @@
// Per-key record of the layer used at press time.
// Layer numbers in a synchronous memory, valid bits in flops; uses kls_pkg.
module kls_press
  import kls_pkg::*;
#(
  parameter int ROWS   = KLS_ROWS,
  parameter int COLS   = KLS_COLS,
  parameter int LAYERS = KLS_LAYERS,
  localparam int KEYS  = ROWS * COLS,
  localparam int KW    = (KEYS > 1) ? $clog2(KEYS) : 1,
  localparam int LW    = $clog2(LAYERS)
) (
  input  logic          clk,
  input  logic          rst,
  input  press_ctl_t    ctl,
  input  logic [KW-1:0] idx,
  input  logic [LW-1:0] wdata,
  output logic          hit,
  output logic [LW-1:0] rdata
);

  logic [KEYS-1:0] valid;
  logic [LW-1:0]   mem [KEYS];

  assign hit = valid[idx];

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.set) begin
      valid[idx] <= 1'b1;
    end else if (ctl.clear) begin
      valid[idx] <= 1'b0;
    end
  end

  // Layer memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.set) begin
      mem[idx] <= wdata;
    end
    rdata <= mem[idx];
  end

endmodule

@@ design/kls_seq.sv @@
// Item sequencer: key lookup, layer stack, modifier and group state.
// Drives the table and press memories and hands results to kls_outbuf;
// uses kls_pkg.
module kls_seq
  import kls_pkg::*;
#(
  parameter int ROWS        = KLS_ROWS,
  parameter int COLS        = KLS_COLS,
  parameter int LAYERS      = KLS_LAYERS,
  parameter int STACK_DEPTH = KLS_STACK_DEPTH,
  localparam int KEYS       = ROWS * COLS,
  localparam int DEPTH      = LAYERS * KEYS,
  localparam int KW         = (KEYS > 1) ? $clog2(KEYS) : 1,
  localparam int AW         = $clog2(DEPTH),
  localparam int LW         = $clog2(LAYERS),
  localparam int SW         = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  logic [2:0]        row,
  input  logic [3:0]        col,
  input  logic              pressed,
  input  logic [2:0]        leds,
  output logic              busy,
  output press_ctl_t        press_ctl,
  output logic [KW-1:0]     press_idx,
  output logic [LW-1:0]     press_wdata,
  input  logic              press_hit,
  input  logic [LW-1:0]     press_rdata,
  output logic [AW-1:0]     km_raddr,
  input  logic [WORD_W-1:0] km_rdata,
  output logic [LW-1:0]     cp_raddr,
  input  logic [WORD_W-1:0] cp_rdata,
  output emit_t             em
);

  typedef enum logic [1:0] {LOP_NONE, LOP_PUSH, LOP_POP, LOP_BASE} layer_op_t;

  localparam logic [SW-1:0] TOP_FULL = SW'(STACK_DEPTH - 1);

  // Layer number modulo LAYERS, as a constant table over the 4-bit field
  function automatic logic [LW-1:0] wrap_layer(input logic [3:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v == 4'(i)) r = LW'(i % LAYERS);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] km_addr(input logic [LW-1:0] layer,
                                            input logic [KW-1:0] key);
    return AW'(layer) * AW'(KEYS) + AW'(key);
  endfunction

  seq_state_t    state, state_next;
  seq_state_t    ret, ret_next;
  logic [LW-1:0] stack [STACK_DEPTH];
  logic [LW-1:0] stack_next [STACK_DEPTH];
  logic [SW-1:0] top, top_next;
  logic [LW-1:0] base, base_next;
  logic [7:0]    amods, amods_next;
  logic          ig, ig_next;
  logic          num, num_next;
  logic [LW-1:0] comp_a, comp_a_next;
  logic [LW-1:0] comp_b, comp_b_next;

  // Latched item
  logic [2:0] it_row;
  logic [3:0] it_col;
  logic       it_pressed;
  logic [2:0] it_leds;

  logic          take;
  logic          in_range;
  logic [KW-1:0] kidx;

  // Leaf execution
  logic [WORD_W-1:0] lf_word;
  logic              lf_pressed;
  logic              lf_hit;
  emit_t             lf_em;
  logic [7:0]        lf_amods;
  logic              lf_ig;

  // Layer stack operation request
  layer_op_t     lop;
  logic [LW-1:0] lop_arg;
  seq_state_t    lop_after;

  assign take      = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign in_range  = (int'(it_row) < ROWS) && (int'(it_col) < COLS);
  assign kidx      = KW'(it_row) * KW'(COLS) + KW'(it_col);
  assign press_idx = kidx;
  assign press_wdata = stack[top];
  assign km_raddr  = km_addr((state == ST_KEY_REL) ? press_rdata : stack[top], kidx);
  assign cp_raddr  = (state == ST_COMP_A_EX) ? comp_b : comp_a;

  // Non-layer entry types: emit at most one action, update modifiers and group flag
  always_comb begin
    lf_word    = (state == ST_ENTRY) ? km_rdata : cp_rdata;
    lf_pressed = (state == ST_ENTRY) ? it_pressed : (state == ST_COMP_B_EX);
    lf_em      = '0;
    lf_amods   = amods;
    lf_ig      = ig;
    lf_hit     = 1'b1;
    lf_em.code        = lf_word[11:4];
    lf_em.act_pressed = lf_pressed;
    case (lf_word[3:0])
      ET_KEY: begin
        lf_em.valid  = 1'b1;
        lf_em.action = ACT_KEY;
        lf_em.mods   = lf_pressed ? lf_word[19:12] : (lf_word[19:12] & ~amods);
        if (lf_word[20]) lf_ig = lf_pressed;
      end
      ET_MOD: begin
        lf_em.valid  = 1'b1;
        lf_em.action = ACT_MOD;
        lf_em.mods   = lf_word[19:12];
        lf_amods     = lf_pressed ? (amods | lf_word[19:12]) : (amods & ~lf_word[19:12]);
        if (lf_word[20]) lf_ig = lf_pressed;
      end
      ET_MOUSE: begin
        lf_em.valid  = 1'b1;
        lf_em.action = ACT_MOUSE;
      end
      ET_CONSUMER: begin
        lf_em.valid  = 1'b1;
        lf_em.action = ACT_CONSUMER;
      end
      ET_SYSTEM: begin
        lf_em.valid  = 1'b1;
        lf_em.action = ACT_SYSTEM;
      end
      ET_COMMAND: begin
        lf_em.valid  = lf_pressed;
        lf_em.action = ACT_COMMAND;
      end
      default: begin
        lf_hit = 1'b0;
      end
    endcase
  end

  // Next state and outputs
  always_comb begin
    state_next  = state;
    ret_next    = ret;
    stack_next  = stack;
    top_next    = top;
    base_next   = base;
    amods_next  = amods;
    ig_next     = ig;
    num_next    = num;
    comp_a_next = comp_a;
    comp_b_next = comp_b;
    press_ctl   = '0;
    em          = '0;
    lop         = LOP_NONE;
    lop_arg     = '0;
    lop_after   = ST_FLUSH;

    case (state)
      ST_IDLE: begin
        if (start) begin
          case (func)
            FN_KEY:  state_next = ST_KEY;
            FN_LED:  state_next = ST_LED_NUM;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      // Record or recall the press layer; on a press the keymap read goes out here
      ST_KEY: begin
        if (!in_range) begin
          state_next = ST_FLUSH;
        end else if (it_pressed) begin
          press_ctl.set = 1'b1;
          state_next    = ST_ENTRY;
        end else if (!press_hit) begin
          state_next = ST_FLUSH;
        end else begin
          press_ctl.clear = 1'b1;
          state_next      = ST_KEY_REL;
        end
      end
      ST_KEY_REL: begin
        state_next = ST_ENTRY;
      end
      // Execute the keymap entry
      ST_ENTRY: begin
        state_next = ST_FLUSH;
        em         = lf_em;
        amods_next = lf_amods;
        ig_next    = lf_ig;
        if (!lf_hit) begin
          case (km_rdata[3:0])
            ET_LAYER: begin
              lop     = it_pressed ? LOP_PUSH : LOP_POP;
              lop_arg = wrap_layer(km_rdata[24:21]);
            end
            ET_LOCK: begin
              if (it_pressed) begin
                em.valid       = 1'b1;
                em.action      = ACT_LOCK;
                em.code        = '0;
                em.mods        = '0;
                em.act_pressed = 1'b1;
                em.led_value   = LOCK_ON;
                stack_next[0]  = wrap_layer(km_rdata[24:21]);
              end
            end
            ET_UNLOCK: begin
              if (it_pressed) begin
                em.valid       = 1'b1;
                em.action      = ACT_LOCK;
                em.code        = '0;
                em.mods        = '0;
                em.act_pressed = 1'b1;
                em.led_value   = LOCK_OFF;
                stack_next[0]  = base;
              end
            end
            ET_BASE_PP: begin
              lop     = it_pressed ? LOP_PUSH : LOP_POP;
              lop_arg = base;
            end
            ET_BASE_SET: begin
              if (it_pressed) begin
                lop     = LOP_BASE;
                lop_arg = wrap_layer(km_rdata[24:21]);
              end
            end
            default: ;
          endcase
        end
      end
      // Companion pair: release old layer's entry, then press new one's
      ST_COMP_A: begin
        state_next = ST_COMP_A_EX;
      end
      ST_COMP_A_EX: begin
        em         = lf_em;
        amods_next = lf_amods;
        ig_next    = lf_ig;
        state_next = ST_COMP_B_EX;
      end
      ST_COMP_B_EX: begin
        em         = lf_em;
        amods_next = lf_amods;
        ig_next    = lf_ig;
        state_next = ret;
      end
      // Host LED report: num lock layer, caps lock base, indicator LEDs
      ST_LED_NUM: begin
        state_next = ST_LED_BASE;
        lop_after  = ST_LED_BASE;
        if (it_leds[0] && !num) begin
          num_next = 1'b1;
          lop      = LOP_PUSH;
          lop_arg  = wrap_layer(LAYER_NUM_LOCK);
        end else if (!it_leds[0] && num) begin
          num_next = 1'b0;
          lop      = LOP_POP;
        end
      end
      ST_LED_BASE: begin
        state_next = ST_LED_EMIT;
        lop_after  = ST_LED_EMIT;
        if (!ig) begin
          lop     = LOP_BASE;
          lop_arg = wrap_layer(it_leds[1] ? LAYER_CAPS_LOCK : LAYER_DEFAULT);
        end
      end
      ST_LED_EMIT: begin
        em.valid     = 1'b1;
        em.action    = ACT_LEDS;
        em.led_value = ig ? ((it_leds & LED_NUM_SCROLL) | LED_CAPS) : it_leds;
        state_next   = ST_FLUSH;
      end
      ST_FLUSH: begin
        em.flush   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Layer stack operations; each sets up a companion pair when it changes layers
    case (lop)
      LOP_PUSH: begin
        if (top != TOP_FULL) begin
          comp_a_next               = stack[top];
          comp_b_next               = lop_arg;
          top_next                  = top + 1'b1;
          stack_next[top + 1'b1]    = lop_arg;
          ret_next                  = lop_after;
          state_next                = ST_COMP_A;
        end else begin
          state_next = lop_after;
        end
      end
      LOP_POP: begin
        if (top == '0) begin
          comp_a_next   = stack[0];
          comp_b_next   = base;
          stack_next[0] = base;
        end else begin
          comp_a_next = stack[top];
          comp_b_next = stack[top - 1'b1];
          top_next    = top - 1'b1;
        end
        ret_next   = lop_after;
        state_next = ST_COMP_A;
      end
      LOP_BASE: begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
          if ((SW'(i) <= top) && (stack[i] == base)) stack_next[i] = lop_arg;
        end
        base_next = lop_arg;
        if (stack[top] == base) begin
          comp_a_next = base;
          comp_b_next = lop_arg;
          ret_next    = lop_after;
          state_next  = ST_COMP_A;
        end else begin
          state_next = lop_after;
        end
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Engine control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= '0;
      top   <= '0;
      base  <= '0;
      amods <= '0;
      ig    <= 1'b0;
      num   <= 1'b0;
      ret   <= ST_FLUSH;
    end else begin
      stack <= stack_next;
      top   <= top_next;
      base  <= base_next;
      amods <= amods_next;
      ig    <= ig_next;
      num   <= num_next;
      ret   <= ret_next;
    end
  end

  // Companion layers and latched item
  always_ff @(posedge clk) begin
    comp_a <= comp_a_next;
    comp_b <= comp_b_next;
    if (take) begin
      it_row     <= row;
      it_col     <= col;
      it_pressed <= pressed;
      it_leds    <= leds;
    end
  end

endmodule

@@ design/kls_outbuf.sv @@
// Result buffer: holds one result back so the final one of an item
// can be marked last, then drives the strobed result ports; uses kls_pkg.
module kls_outbuf
  import kls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  emit_t      em,
  output logic       strobe,
  output logic [2:0] action,
  output logic [7:0] code,
  output logic [7:0] mods,
  output logic       act_pressed,
  output logic [2:0] led_value,
  output logic       last
);

  emit_t pend;
  logic  pend_valid;

  // Control: strobe and held-result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe <= pend_valid && (em.valid || em.flush);
      if (em.valid) begin
        pend_valid <= 1'b1;
      end else if (em.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload: a new result pushes the held one out, a flush ends the item
  always_ff @(posedge clk) begin
    if (em.valid) begin
      pend <= em;
    end
    if (em.valid || em.flush) begin
      action      <= pend.action;
      code        <= pend.code;
      mods        <= pend.mods;
      act_pressed <= pend.act_pressed;
      led_value   <= pend.led_value;
      last        <= !em.valid;
    end
  end

endmodule

@@ design/keymap_layer_stack_engine_core.sv @@
// Top level of the keymap layer stack engine.
// Instantiates kls_tables, kls_press, kls_seq and kls_outbuf; uses kls_pkg.
//
// A command is taken when start is high and busy is low. Table writes
// (keymap and companion entries) leave busy low, so they can stream at one
// per clock. A key press holds busy through the key, entry and flush states;
// a release that finds its press record also passes the key-release state
// for the press-layer read, and one with no record goes from the key state
// straight to flush. Each layer change the entry makes adds the companion
// states for the two companion lookups. A host LED report steps through num
// lock, base, LED emit and flush, plus companion states per layer change.
// Results leave one per strobe cycle and cannot be held off; the last result
// of an item carries last and strobes in the first cycle with busy low.
// Items that only write tables, or key events that miss, produce no results.
module keymap_layer_stack_engine_core
  import kls_pkg::*;
#(
  parameter int ROWS        = KLS_ROWS,
  parameter int COLS        = KLS_COLS,
  parameter int LAYERS      = KLS_LAYERS,
  parameter int STACK_DEPTH = KLS_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  logic [2:0]        row,
  input  logic [3:0]        col,
  input  logic              pressed,
  input  logic [2:0]        leds,
  input  logic [10:0]       table_index,
  input  logic [WORD_W-1:0] table_word,
  output logic              busy,
  output logic              strobe,
  output logic [2:0]        action,
  output logic [7:0]        code,
  output logic [7:0]        mods,
  output logic              act_pressed,
  output logic [2:0]        led_value,
  output logic              last
);

  localparam int KEYS  = ROWS * COLS;
  localparam int DEPTH = LAYERS * KEYS;
  localparam int KW    = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(LAYERS);

  logic              take;
  press_ctl_t        press_ctl;
  logic [KW-1:0]     press_idx;
  logic [LW-1:0]     press_wdata;
  logic              press_hit;
  logic [LW-1:0]     press_rdata;
  logic [AW-1:0]     km_raddr;
  logic [WORD_W-1:0] km_rdata;
  logic [LW-1:0]     cp_raddr;
  logic [WORD_W-1:0] cp_rdata;
  emit_t             em;

  assign take = start && !busy;

  kls_tables #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .LAYERS (LAYERS)
  ) u_tables (
    .clk         (clk),
    .take        (take),
    .func        (func),
    .table_index (table_index),
    .table_word  (table_word),
    .km_raddr    (km_raddr),
    .km_rdata    (km_rdata),
    .cp_raddr    (cp_raddr),
    .cp_rdata    (cp_rdata)
  );

  kls_press #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .LAYERS (LAYERS)
  ) u_press (
    .clk   (clk),
    .rst   (rst),
    .ctl   (press_ctl),
    .idx   (press_idx),
    .wdata (press_wdata),
    .hit   (press_hit),
    .rdata (press_rdata)
  );

  kls_seq #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .LAYERS      (LAYERS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .row         (row),
    .col         (col),
    .pressed     (pressed),
    .leds        (leds),
    .busy        (busy),
    .press_ctl   (press_ctl),
    .press_idx   (press_idx),
    .press_wdata (press_wdata),
    .press_hit   (press_hit),
    .press_rdata (press_rdata),
    .km_raddr    (km_raddr),
    .km_rdata    (km_rdata),
    .cp_raddr    (cp_raddr),
    .cp_rdata    (cp_rdata),
    .em          (em)
  );

  kls_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .em          (em),
    .strobe      (strobe),
    .action      (action),
    .code        (code),
    .mods        (mods),
    .act_pressed (act_pressed),
    .led_value   (led_value),
    .last        (last)
  );

  // An idle sequencer produces no results and no end-of-item marker
  assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!em.valid && !em.flush))
    else $error("sequencer output while idle");

  // End of item returns the sequencer to idle
  assert property (@(posedge clk) disable iff (rst)
    em.flush |=> !busy)
    else $error("sequencer busy after end of item");

  // Table writes never occupy the sequencer
  assert property (@(posedge clk) disable iff (rst)
    (take && (func == FN_WR_KEYMAP || func == FN_WR_COMP)) |=> !busy)
    else $error("table write left the block busy");

  // The last result of an item is never followed at once by another
  assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("result transfer right after last");

endmodule

@@ sim/tb_top.sv @@
// Testbench for keymap_layer_stack_engine_core: command transfers in, action transfers out.
// A clocked driver and monitor check every action against a layered keymap predictor
// kept here; uses kls_pkg.
`timescale 1ns / 1ps

module tb_top;
  import kls_pkg::*;

  localparam int RANDOM_ITEMS = 160;
  localparam int KEY_COUNT    = KLS_ROWS * KLS_COLS;
  localparam int MAP_DEPTH    = KLS_LAYERS * KEY_COUNT;
  // Keys in use: row 0 columns 0..9 and row 1 columns 0..3, on layers 0, 2, 4, 6
  localparam int USED_LAYERS  = 4;
  localparam int CTRL_COLS    = 10;
  localparam int EXTRA_COLS   = 4;

  // One command as presented on the input ports, plus the sender's idle rate
  typedef struct {
    logic [1:0]        func;
    logic [2:0]        row;
    logic [3:0]        col;
    logic              pressed;
    logic [2:0]        leds;
    logic [10:0]       table_index;
    logic [WORD_W-1:0] table_word;
    int unsigned       idle_pct;
  } kl_cmd_t;

  // One output action
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] code;
    logic [7:0] mods;
    logic       act_pressed;
    logic [2:0] led_value;
    logic       last;
  } action_rec_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        func = FN_KEY;
  logic [2:0]        row = '0;
  logic [3:0]        col = '0;
  logic              pressed = 1'b0;
  logic [2:0]        leds = '0;
  logic [10:0]       table_index = '0;
  logic [WORD_W-1:0] table_word = '0;
  logic              busy;
  logic              strobe;
  logic [2:0]        action;
  logic [7:0]        code;
  logic [7:0]        mods;
  logic              act_pressed;
  logic [2:0]        led_value;
  logic              last;

  kl_cmd_t     cmd_q[$];
  kl_cmd_t     cur_cmd;
  action_rec_t action_q[$];
  action_rec_t step_q[$];
  int          errors = 0;
  int unsigned cur_pct = 19;
  int unsigned n_queued = 0;

  // Predictor state
  logic [WORD_W-1:0] keymap_model [0:MAP_DEPTH-1];
  logic [WORD_W-1:0] comp_model [0:KLS_LAYERS-1];
  logic [3:0]        stack_model [0:KLS_STACK_DEPTH-1];
  int unsigned       top_model;
  logic [3:0]        base_model;
  logic [7:0]        mods_model;
  logic              num_model;
  logic              grp_model;
  logic [4:0]        press_model [0:KEY_COUNT-1];

  always #4 clk = ~clk;

  keymap_layer_stack_engine_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .row         (row),
    .col         (col),
    .pressed     (pressed),
    .leds        (leds),
    .table_index (table_index),
    .table_word  (table_word),
    .busy        (busy),
    .strobe      (strobe),
    .action      (action),
    .code        (code),
    .mods        (mods),
    .act_pressed (act_pressed),
    .led_value   (led_value),
    .last        (last)
  );

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  function automatic void put_action(logic [2:0] a, logic [7:0] c, logic [7:0] m,
                                     logic p, logic [2:0] l);
    step_q.push_back('{action: a, code: c, mods: m, act_pressed: p, led_value: l,
                       last: 1'b0});
  endfunction

  // Plain (non-layer) entries; returns 0 when the entry type is not one of them
  function automatic bit leaf_action(logic [WORD_W-1:0] w, logic p);
    logic [7:0] c;
    logic [7:0] m;
    c = w[11:4];
    m = w[19:12];
    leaf_action = 1'b1;
    case (w[3:0])
      ET_KEY: begin
        if (!p) m = m & ~mods_model;
        if (w[20]) grp_model = p;
        put_action(ACT_KEY, c, m, p, '0);
      end
      ET_MOD: begin
        if (p) mods_model = mods_model | m;
        else mods_model = mods_model & ~m;
        if (w[20]) grp_model = p;
        put_action(ACT_MOD, c, m, p, '0);
      end
      ET_MOUSE:    put_action(ACT_MOUSE, c, '0, p, '0);
      ET_CONSUMER: put_action(ACT_CONSUMER, c, '0, p, '0);
      ET_SYSTEM:   put_action(ACT_SYSTEM, c, '0, p, '0);
      ET_COMMAND: begin
        if (p) put_action(ACT_COMMAND, c, '0, 1'b1, '0);
      end
      default: leaf_action = 1'b0;
    endcase
  endfunction

  function automatic void companion_action(logic [3:0] layer, logic p);
    void'(leaf_action(comp_model[layer], p));
  endfunction

  function automatic void stack_push(logic [3:0] layer);
    if (top_model >= KLS_STACK_DEPTH - 1) return;
    companion_action(stack_model[top_model], 1'b0);
    top_model++;
    stack_model[top_model] = layer;
    companion_action(layer, 1'b1);
  endfunction

  // Popping the bottom entry reloads it with the base layer
  function automatic void stack_pop();
    if (top_model == 0) begin
      companion_action(stack_model[0], 1'b0);
      stack_model[0] = base_model;
      companion_action(base_model, 1'b1);
    end else begin
      companion_action(stack_model[top_model], 1'b0);
      companion_action(stack_model[top_model-1], 1'b1);
      top_model--;
    end
  endfunction

  function automatic void set_base(logic [3:0] nb);
    if (stack_model[top_model] == base_model) begin
      companion_action(base_model, 1'b0);
      companion_action(nb, 1'b1);
    end
    for (int i = 0; i <= top_model; i++)
      if (stack_model[i] == base_model) stack_model[i] = nb;
    base_model = nb;
  endfunction

  function automatic void entry_action(logic [WORD_W-1:0] w, logic p);
    logic [3:0] layer;
    layer = w[24:21];
    if (leaf_action(w, p)) return;
    case (w[3:0])
      ET_LAYER: begin
        if (p) stack_push(layer);
        else stack_pop();
      end
      ET_LOCK: begin
        if (p) begin
          put_action(ACT_LOCK, '0, '0, 1'b1, LOCK_ON);
          stack_model[0] = layer;
        end
      end
      ET_UNLOCK: begin
        if (p) begin
          put_action(ACT_LOCK, '0, '0, 1'b1, LOCK_OFF);
          stack_model[0] = base_model;
        end
      end
      ET_BASE_PP: begin
        if (p) stack_push(base_model);
        else stack_pop();
      end
      ET_BASE_SET: begin
        if (p) set_base(layer);
      end
      default: ;
    endcase
  endfunction

  // Works out the actions of one accepted command and queues them
  function automatic void predict_actions(kl_cmd_t t);
    logic [6:0] key;
    logic [3:0] layer;
    step_q.delete();
    key = {t.row, t.col};
    case (t.func)
      FN_KEY: begin
        if (t.pressed) begin
          layer = stack_model[top_model];
          press_model[key] = {1'b1, layer};
          entry_action(keymap_model[{layer, key}], 1'b1);
        end else if (press_model[key][4]) begin
          layer = press_model[key][3:0];
          press_model[key] = '0;
          entry_action(keymap_model[{layer, key}], 1'b0);
        end
      end
      FN_LED: begin
        if (t.leds[0]) begin
          if (!num_model) begin
            num_model = 1'b1;
            stack_push(LAYER_NUM_LOCK);
          end
        end else if (num_model) begin
          num_model = 1'b0;
          stack_pop();
        end
        if (!grp_model) set_base(t.leds[1] ? LAYER_CAPS_LOCK : LAYER_DEFAULT);
        if (grp_model) put_action(ACT_LEDS, '0, '0, 1'b0, (t.leds & LED_NUM_SCROLL) | LED_CAPS);
        else put_action(ACT_LEDS, '0, '0, 1'b0, t.leds);
      end
      FN_WR_KEYMAP: keymap_model[t.table_index] = t.table_word;
      default: begin
        if (t.table_index < KLS_LAYERS) comp_model[t.table_index[3:0]] = t.table_word;
      end
    endcase
    if (step_q.size() != 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) action_q.push_back(step_q[i]);
  endfunction

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  function automatic logic [WORD_W-1:0] make_word(logic [3:0] et, logic [7:0] c,
                                                  logic [7:0] m, logic ig, logic [3:0] layer);
    return {layer, ig, m, c, et};
  endfunction

  // One of the layers in use
  function automatic logic [3:0] rand_layer();
    return 4'(2 * $urandom_range(USED_LAYERS - 1));
  endfunction

  // Random entry, weighted toward the types that produce actions
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    int unsigned r;
    w = WORD_W'($urandom);
    r = $urandom_range(99);
    if (r < 25) w[3:0] = ET_KEY;
    else if (r < 40) w[3:0] = ET_MOD;
    else if (r < 48) w[3:0] = ET_MOUSE;
    else if (r < 54) w[3:0] = ET_CONSUMER;
    else if (r < 58) w[3:0] = ET_SYSTEM;
    else if (r < 70) w[3:0] = ET_LAYER;
    else if (r < 74) w[3:0] = ET_LOCK;
    else if (r < 78) w[3:0] = ET_UNLOCK;
    else if (r < 84) w[3:0] = ET_BASE_PP;
    else if (r < 88) w[3:0] = ET_BASE_SET;
    else if (r < 93) w[3:0] = ET_COMMAND;
    else if (r < 96) w[3:0] = ET_NONE;
    w[24:21] = rand_layer();
    return w;
  endfunction

  // Row 0, columns 0..8 hold the same control entry on every layer
  function automatic logic [WORD_W-1:0] ctrl_word(logic [3:0] c);
    case (c)
      4'd0:    return make_word(ET_MOD, 8'hFF, 8'hFF, 1'b1, 4'd0);
      4'd1:    return make_word(ET_LAYER, 8'h11, 8'h00, 1'b0, 4'd6);
      4'd2:    return make_word(ET_LOCK, 8'h22, 8'h00, 1'b0, 4'd6);
      4'd3:    return make_word(ET_UNLOCK, 8'h33, 8'h00, 1'b0, 4'd0);
      4'd4:    return make_word(ET_BASE_PP, 8'h44, 8'h00, 1'b0, 4'd0);
      4'd5:    return make_word(ET_BASE_SET, 8'h55, 8'h00, 1'b0, 4'd6);
      4'd6:    return make_word(ET_COMMAND, 8'h5A, 8'h00, 1'b0, 4'd0);
      4'd7:    return make_word(ET_KEY, 8'hAA, 8'h0F, 1'b0, 4'd0);
      default: return make_word(4'd15, 8'h00, 8'h00, 1'b1, 4'd15);
    endcase
  endfunction

  // Fields that the command does not use carry random noise
  function automatic kl_cmd_t blank_cmd(logic [1:0] f);
    kl_cmd_t t;
    t.func        = f;
    t.row         = 3'($urandom);
    t.col         = 4'($urandom);
    t.pressed     = 1'($urandom);
    t.leds        = 3'($urandom);
    t.table_index = 11'($urandom);
    t.table_word  = WORD_W'($urandom);
    t.idle_pct    = cur_pct;
    n_queued++;
    return t;
  endfunction

  function automatic void queue_key(logic [2:0] r, logic [3:0] c, logic p);
    kl_cmd_t t;
    t = blank_cmd(FN_KEY);
    t.row = r;
    t.col = c;
    t.pressed = p;
    cmd_q.push_back(t);
  endfunction

  function automatic void queue_led(logic [2:0] l);
    kl_cmd_t t;
    t = blank_cmd(FN_LED);
    t.leds = l;
    cmd_q.push_back(t);
  endfunction

  function automatic void queue_write(logic [1:0] f, logic [10:0] idx, logic [WORD_W-1:0] w);
    kl_cmd_t t;
    t = blank_cmd(f);
    t.table_index = idx;
    t.table_word = w;
    cmd_q.push_back(t);
  endfunction

  // Random key: a control key on row 0 or one of the keys on row 1
  function automatic void queue_rand_key(logic p);
    if ($urandom_range(99) < 40) queue_key(3'd0, 4'($urandom_range(8)), p);
    else queue_key(3'd1, 4'($urandom_range(EXTRA_COLS - 1)), p);
  endfunction

  // ---------------------------------------------------------------
  // Driver: one command at a time, random sender gaps
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_actions(cur_cmd);
      if (!(start && busy)) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= cmd_q[0].idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          start       <= 1'b1;
          func        <= cur_cmd.func;
          row         <= cur_cmd.row;
          col         <= cur_cmd.col;
          pressed     <= cur_cmd.pressed;
          leds        <= cur_cmd.leds;
          table_index <= cur_cmd.table_index;
          table_word  <= cur_cmd.table_word;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor: each strobe is one action transfer
  // ---------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : action_check
    action_rec_t want;
    if (!rst && strobe) begin
      if (action_q.size() == 0) begin
        $display("%0t: unexpected action %h code %h, expected none", $time, action, code);
        errors++;
      end else begin
        want = action_q.pop_front();
        check_field("action", 8'(want.action), 8'(action));
        check_field("code", want.code, code);
        check_field("mods", want.mods, mods);
        check_field("act_pressed", 8'(want.act_pressed), 8'(act_pressed));
        check_field("led_value", 8'(want.led_value), 8'(led_value));
        check_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------
  initial begin : stimulus
    int unsigned guard;
    int unsigned r;
    int unsigned n;
    int unsigned m;

    // Predictor reset state
    for (int i = 0; i < KLS_STACK_DEPTH; i++) stack_model[i] = '0;
    for (int i = 0; i < KEY_COUNT; i++) press_model[i] = '0;
    top_model  = 0;
    base_model = '0;
    mods_model = '0;
    num_model  = 1'b0;
    grp_model  = 1'b0;

    // Load the keymap and companion entries of the keys and layers in use
    for (int l = 0; l < USED_LAYERS; l++) begin
      for (int c = 0; c < CTRL_COLS; c++) begin
        if (c <= 8) queue_write(FN_WR_KEYMAP, {4'(2 * l), 3'd0, 4'(c)}, ctrl_word(4'(c)));
        else queue_write(FN_WR_KEYMAP, {4'(2 * l), 3'd0, 4'(c)}, rand_word());
      end
      for (int c = 0; c < EXTRA_COLS; c++)
        queue_write(FN_WR_KEYMAP, {4'(2 * l), 3'd1, 4'(c)}, rand_word());
      queue_write(FN_WR_COMP, 11'(2 * l), rand_word());
    end

    // Directed: modifier with ignore group, key release masking, num lock
    queue_key(3'd0, 4'd0, 1'b1);
    queue_key(3'd0, 4'd7, 1'b1);
    queue_led(3'd7);
    queue_key(3'd0, 4'd7, 1'b0);
    queue_key(3'd0, 4'd0, 1'b0);
    queue_key(3'd0, 4'd0, 1'b0);        // release with nothing recorded
    queue_led(3'd0);
    // Entry rewritten between press and release: the release pops at the bottom
    queue_write(FN_WR_KEYMAP, 11'd9, make_word(ET_KEY, 8'h00, 8'h00, 1'b0, 4'd0));
    queue_key(3'd0, 4'd9, 1'b1);
    queue_write(FN_WR_KEYMAP, 11'd9, make_word(ET_LAYER, 8'h00, 8'h00, 1'b0, 4'd5));
    queue_key(3'd0, 4'd9, 1'b0);
    // Command, lock, unlock, base change, caps lock, empty entry
    queue_key(3'd0, 4'd6, 1'b1);
    queue_key(3'd0, 4'd2, 1'b1);
    queue_key(3'd0, 4'd3, 1'b1);
    queue_key(3'd0, 4'd5, 1'b1);
    queue_led(3'd2);
    queue_key(3'd0, 4'd8, 1'b1);
    queue_write(FN_WR_COMP, 11'd16, '1);  // companion index out of range
    // Stack fills up; the last push is dropped
    queue_key(3'd0, 4'd4, 1'b1);
    for (int i = 0; i < 7; i++) queue_key(3'd0, 4'd1, 1'b1);
    queue_key(3'd0, 4'd1, 1'b0);
    queue_key(3'd0, 4'd4, 1'b0);

    // Random: mostly press/release pairs, plus noise, reports and rewrites
    n_queued = 0;
    while (n_queued < RANDOM_ITEMS) begin
      cur_pct = (n_queued < RANDOM_ITEMS / 3) ? 19 : (n_queued < 2 * RANDOM_ITEMS / 3) ? 75 : 0;
      r = $urandom_range(99);
      if (r < 50) begin
        if ($urandom_range(99) < 40) begin
          n = $urandom_range(8);
          queue_key(3'd0, 4'(n), 1'b1);
          if ($urandom_range(1)) queue_rand_key(1'b1);
          else if ($urandom_range(1)) queue_led(3'($urandom));
          queue_key(3'd0, 4'(n), 1'b0);
        end else begin
          m = $urandom_range(EXTRA_COLS - 1);
          queue_key(3'd1, 4'(m), 1'b1);
          if ($urandom_range(1)) queue_rand_key(1'b1);
          queue_key(3'd1, 4'(m), 1'b0);
        end
      end else if (r < 62) begin
        queue_rand_key(1'($urandom));
      end else if (r < 72) begin
        queue_led(3'($urandom));
      end else if (r < 84) begin
        queue_write(FN_WR_KEYMAP, 11'($urandom), rand_word());
      end else if (r < 90) begin
        if ($urandom_range(3) != 0) queue_write(FN_WR_COMP, 11'($urandom_range(15)), rand_word());
        else queue_write(FN_WR_COMP, 11'($urandom), rand_word());
      end else begin
        n = $urandom_range(9, 3);
        for (int i = 0; i < n; i++) queue_key(3'd0, $urandom_range(1) ? 4'd1 : 4'd4, 1'b1);
        queue_key(3'd0, 4'd1, 1'b0);
        queue_key(3'd0, 4'd4, 1'b0);
        queue_led(3'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: all commands transferred, then all actions seen
    while (cmd_q.size() != 0 || start) @(posedge clk);
    guard = 0;
    while ((action_q.size() != 0 || busy) && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (action_q.size() != 0) begin
      $display("%0t: %0d expected actions never arrived", $time, action_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
